[src/mci_pkg.sv]
package mci_pkg;

  localparam int MaxPoints = 16;
  localparam int IdxW = $clog2(MaxPoints);
  localparam int CntW = 5;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_SAT  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_FIRST, S_LAST, S_SCAN, S_FETCH, S_LOAD, S_MUL, S_DIV, S_ADD, S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             rd_en;
    logic [IdxW-1:0]  rd_idx;
    logic             cap_a;     // capture read data as left point
    logic             cap_b;     // capture read data as right point
    logic             mul;
    logic             div_start;
    logic             div_step;
    logic             add;
    logic             set_t0;    // result is left time or the entry just read, status given
    logic [1:0]       st_code;
  } cmd_t;

  // Status returned to the controller.
  typedef struct packed {
    logic lt_first;   // query below offset of the entry just read
    logic ge_last;    // query at or above offset of the entry just read
    logic in_seg;     // left <= q < right
    logic zero_w;     // right offset equals left offset
  } stat_t;

endpackage

[src/mci_if.sv]
interface mci_in_if (input logic clk);
  logic        valid;
  logic        ready;
  logic        operation;
  logic [3:0]  point_index;
  logic signed [31:0] point_time;
  logic signed [31:0] point_offset;
  logic signed [31:0] query_offset;
  modport source (output valid, operation, point_index, point_time, point_offset,
                  query_offset, input ready);
  modport sink (input valid, operation, point_index, point_time, point_offset,
                query_offset, output ready);
endinterface

interface mci_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic signed [31:0] mute_time;
  logic [1:0]  status;
  modport source (output valid, mute_time, status, input ready);
  modport sink (input valid, mute_time, status, output ready);
endinterface

[src/mci_datapath.sv]
module mci_datapath (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [mci_pkg::IdxW-1:0] wr_idx,
  input  logic signed [31:0]     wr_time,
  input  logic signed [31:0]     wr_offset,
  input  logic                   q_load,
  input  logic signed [31:0]     q_in,
  input  mci_pkg::cmd_t          cmd,
  output mci_pkg::stat_t         stat,
  output logic signed [31:0]     res_time,
  output logic [1:0]             res_status
);

  logic [63:0] mem [mci_pkg::MaxPoints];
  logic [63:0] rd_data;
  logic signed [31:0] q, ta, oa, tb, ob;
  logic signed [32:0] dt, dx, dd;
  logic [32:0] adt, adx, add_abs;
  logic [65:0] prod;
  logic [65:0] rem;
  logic [65:0] quo;
  logic        neg;
  logic [65:0] rem_sh;
  logic signed [35:0] sum;

  // Breakpoint memory: time in the upper half, offset in the lower.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= {wr_time, wr_offset};
    if (cmd.rd_en) rd_data <= mem[cmd.rd_idx];
  end

  always_ff @(posedge clk) begin
    if (q_load) q <= q_in;
  end

  // Point capture.
  always_ff @(posedge clk) begin
    if (cmd.cap_a) begin
      ta <= rd_data[63:32];
      oa <= rd_data[31:0];
    end
    if (cmd.cap_b) begin
      tb <= rd_data[63:32];
      ob <= rd_data[31:0];
    end
  end

  // First and last checks use the freshly read entry; the segment test uses captured points.
  always_comb begin
    stat.lt_first = q < $signed(rd_data[31:0]);
    stat.ge_last  = !(q < $signed(rd_data[31:0]));
    stat.in_seg   = (oa <= q) && (q < ob);
    stat.zero_w   = (ob == oa);
  end

  assign dt = 33'(tb) - 33'(ta);
  assign dx = 33'(q) - 33'(oa);
  assign dd = 33'(ob) - 33'(oa);
  assign adt = dt[32] ? 33'(-dt) : 33'(dt);
  assign adx = dx[32] ? 33'(-dx) : 33'(dx);
  assign add_abs = dd[32] ? 33'(-dd) : 33'(dd);

  // Product register, then restoring division one bit a cycle.
  assign rem_sh = {rem[64:0], quo[65]};
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= 66'(adt) * 66'(adx);
      neg  <= (dt[32] ^ dx[32]) ^ dd[32];
    end
    if (cmd.div_start) begin
      rem  <= '0;
      quo  <= prod;
    end else if (cmd.div_step) begin
      if (rem_sh >= 66'(add_abs)) begin
        rem <= rem_sh - 66'(add_abs);
        quo <= {quo[64:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[64:0], 1'b0};
      end
    end
  end

  // Clamp quotient to 2^33, add and saturate.
  always_comb begin
    logic [33:0] qc;
    qc = (quo > 66'h2_0000_0000) ? 34'h2_0000_0000 : quo[33:0];
    sum = neg ? (36'(ta) - 36'(qc)) : (36'(ta) + 36'(qc));
  end

  // A zero-width segment returns its left time, other set_t0 results the entry just read; add stores the saturated sum.
  always_ff @(posedge clk) begin
    if (cmd.set_t0) begin
      res_time   <= (cmd.st_code == mci_pkg::ST_ZERO) ? ta : rd_data[63:32];
      res_status <= cmd.st_code;
    end else if (cmd.add) begin
      if (sum > 36'sh0_7FFF_FFFF) begin
        res_time <= 32'sh7FFF_FFFF; res_status <= mci_pkg::ST_SAT;
      end else if (sum < -36'sh0_8000_0000) begin
        res_time <= 32'sh8000_0000; res_status <= mci_pkg::ST_SAT;
      end else begin
        res_time <= sum[31:0]; res_status <= mci_pkg::ST_OK;
      end
    end
  end

endmodule

[src/mci_control.sv]
module mci_control (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_op,
  input  logic [mci_pkg::CntW-1:0] point_count,
  output logic                   q_load,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  mci_pkg::stat_t         stat,
  output mci_pkg::cmd_t          cmd
);

  mci_pkg::state_t state, state_next;
  logic [mci_pkg::CntW-1:0] n;
  logic [mci_pkg::IdxW:0] idx, idx_next, seg, seg_next;
  logic hit, hit_next;
  logic miss, miss_next;
  logic [6:0] cnt, cnt_next;
  logic [1:0] phase, phase_next;

  // Effective count, clamped to 1..MaxPoints.
  always_comb begin
    if (point_count == '0) n = 5'd1;
    else if (point_count > 5'(mci_pkg::MaxPoints)) n = 5'(mci_pkg::MaxPoints);
    else n = point_count;
  end

  assign in_ready = (state == mci_pkg::S_IDLE);
  assign q_load   = in_ready && in_valid && (in_op == mci_pkg::OP_QUERY);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mci_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == mci_pkg::S_OUT) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
    idx <= idx_next; seg <= seg_next; hit <= hit_next; miss <= miss_next;
    cnt <= cnt_next; phase <= phase_next;
  end

  // Next state and counters.
  always_comb begin
    state_next = state;
    idx_next = idx; seg_next = seg; hit_next = hit; miss_next = miss;
    cnt_next = cnt; phase_next = phase;
    unique case (state)
      mci_pkg::S_IDLE: begin
        if (in_valid && !out_valid && in_op == mci_pkg::OP_QUERY) begin
          state_next = mci_pkg::S_FIRST; phase_next = 2'd0; miss_next = 1'b0;
        end
      end
      // Phase 0: read entry 0; 1: compare, then output, fetch or check last.
      mci_pkg::S_FIRST: begin
        phase_next = phase + 2'd1;
        if (phase == 2'd1) begin
          if (n < 5'd2) state_next = mci_pkg::S_OUT;
          else if (stat.lt_first) begin
            idx_next = '0; state_next = mci_pkg::S_FETCH; phase_next = 2'd0;
          end else begin
            state_next = mci_pkg::S_LAST; phase_next = 2'd0;
          end
        end
      end
      mci_pkg::S_LAST: begin
        phase_next = phase + 2'd1;
        if (phase == 2'd1) begin
          if (stat.ge_last) begin
            idx_next = 5'(n - 5'd2); state_next = mci_pkg::S_FETCH; phase_next = 2'd0;
          end else begin
            idx_next = '0; hit_next = 1'b0; state_next = mci_pkg::S_SCAN;
            phase_next = 2'd0;
          end
        end
      end
      // Scan each segment: read left, read right, test.
      mci_pkg::S_SCAN: begin
        phase_next = phase + 2'd1;
        if (phase == 2'd3) begin
          phase_next = 2'd0;
          if (stat.in_seg) begin hit_next = 1'b1; seg_next = idx; end
          if (5'(idx) + 5'd2 >= n) begin
            if (hit || stat.in_seg) begin
              idx_next = stat.in_seg ? idx : seg;
              state_next = mci_pkg::S_FETCH;
            end else begin
              miss_next = 1'b1;
              state_next = mci_pkg::S_OUT;
            end
          end else idx_next = idx + 1'b1;
        end
      end
      mci_pkg::S_FETCH: begin
        phase_next = phase + 2'd1;
        if (phase == 2'd3) state_next = mci_pkg::S_LOAD;
      end
      mci_pkg::S_LOAD: begin
        state_next = stat.zero_w ? mci_pkg::S_OUT : mci_pkg::S_MUL;
      end
      mci_pkg::S_MUL: begin
        state_next = mci_pkg::S_DIV; cnt_next = '0;
      end
      mci_pkg::S_DIV: begin
        cnt_next = cnt + 7'd1;
        if (cnt == 7'd66) state_next = mci_pkg::S_ADD;
      end
      mci_pkg::S_ADD: state_next = mci_pkg::S_OUT;
      mci_pkg::S_OUT: state_next = mci_pkg::S_IDLE;
      default: state_next = mci_pkg::S_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd = '0;
    unique case (state)
      mci_pkg::S_FIRST: begin
        cmd.rd_en = (phase == 2'd0);
        cmd.rd_idx = '0;
        if (phase == 2'd1) begin
          cmd.cap_a = 1'b1;
          if (n < 5'd2) begin cmd.set_t0 = 1'b1; cmd.st_code = mci_pkg::ST_OK; end
        end
      end
      mci_pkg::S_LAST: begin
        cmd.rd_en = (phase == 2'd0);
        cmd.rd_idx = mci_pkg::IdxW'(n - 5'd1);
      end
      mci_pkg::S_SCAN: begin
        cmd.rd_en = (phase == 2'd0) || (phase == 2'd1);
        cmd.rd_idx = (phase == 2'd0) ? idx[mci_pkg::IdxW-1:0]
                                     : mci_pkg::IdxW'(idx + 1'b1);
        cmd.cap_a = (phase == 2'd1);
        cmd.cap_b = (phase == 2'd2);
        if (phase == 2'd3 && 5'(idx) + 5'd2 >= n && !(hit || stat.in_seg)) begin
          cmd.rd_en = 1'b1; cmd.rd_idx = '0;
        end
      end
      mci_pkg::S_FETCH: begin
        cmd.rd_en = (phase == 2'd0) || (phase == 2'd1);
        cmd.rd_idx = (phase == 2'd0) ? idx[mci_pkg::IdxW-1:0]
                                     : mci_pkg::IdxW'(idx + 1'b1);
        cmd.cap_a = (phase == 2'd1);
        cmd.cap_b = (phase == 2'd2);
      end
      mci_pkg::S_LOAD: begin
        if (stat.zero_w) begin cmd.set_t0 = 1'b1; cmd.st_code = mci_pkg::ST_ZERO; end
      end
      mci_pkg::S_MUL: begin cmd.mul = 1'b1; end
      mci_pkg::S_DIV: begin
        cmd.div_start = (cnt == 7'd0);
        cmd.div_step = (cnt != 7'd0);
      end
      mci_pkg::S_ADD: cmd.add = 1'b1;
      mci_pkg::S_OUT: begin
        // A scan that found nothing returns entry zero's time.
        if (miss) begin cmd.set_t0 = 1'b1; cmd.st_code = mci_pkg::ST_MISS; end
      end
      default: cmd = '0;
    endcase
  end

endmodule

[src/mute_curve_interpolator.sv]
// Channel  Dir  Payload
// in       sink operation, point_index, point_time, point_offset, query_offset
// out      src  mute_time, status
// cfg      APB  point_count at address 0
// A load is written into the table when taken. A query's result is raised once the
// first check settles it with one point in use; below or above the table the end
// segment is fetched, inside it each segment is scanned in turn, then the restoring divider runs.
// A zero-width segment or a scan that finds nothing skips the divider.
// Reset (rst, synchronous) sets point_count to 1 and empties the output.
// A new item is taken only once the previous result has been delivered.
module mute_curve_interpolator (
  input  logic        clk,
  input  logic        rst,
  mci_in_if.sink      in_ch,
  mci_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [mci_pkg::CntW-1:0] point_count;
  mci_pkg::cmd_t  cmd;
  mci_pkg::stat_t stat;
  logic q_load, load_wr, ready_c;

  // Configuration register.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) point_count <= 5'd1;
    else if (psel && penable && pwrite && paddr == 3'd0) point_count <= pwdata[4:0];
  end
  assign prdata = (paddr == 3'd0) ? {27'd0, point_count} : 32'd0;

  assign in_ch.ready = ready_c && !(out_ch.valid);
  assign load_wr = in_ch.valid && in_ch.ready && (in_ch.operation == mci_pkg::OP_LOAD);

  mci_control u_ctrl (
    .clk, .rst, .in_valid(in_ch.valid && !out_ch.valid), .in_ready(ready_c),
    .in_op(in_ch.operation), .point_count, .q_load, .out_valid(out_ch.valid),
    .out_ready(out_ch.ready), .stat, .cmd
  );

  mci_datapath u_dp (
    .clk, .wr_en(load_wr), .wr_idx(in_ch.point_index), .wr_time(in_ch.point_time),
    .wr_offset(in_ch.point_offset), .q_load, .q_in(in_ch.query_offset), .cmd, .stat,
    .res_time(out_ch.mute_time), .res_status(out_ch.status)
  );

endmodule

[sim/mute_curve_interpolator_tb.sv]
`timescale 1ns / 100ps

module mute_curve_interpolator_tb;

  typedef struct {
    logic               operation;
    logic [3:0]         point_index;
    logic signed [31:0] point_time;
    logic signed [31:0] point_offset;
    logic signed [31:0] query_offset;
  } mci_request_t;

  typedef struct {
    logic signed [31:0] mute_time;
    logic [1:0]         status;
  } mute_result_t;

  localparam int CycleLimit = 3000000;
  localparam int DrainCycles = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  mci_in_if  in_ch (clk);
  mci_out_if out_ch (clk);

  mute_curve_interpolator uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Requests waiting to be driven and results waiting to arrive.
  mci_request_t pending_requests[$];
  mute_result_t expected_mutes[$];

  // Predictor state: the table and the point count as the block should hold them.
  longint      model_times[mci_pkg::MaxPoints];
  longint      model_offsets[mci_pkg::MaxPoints];
  logic [4:0]  model_count = 5'd1;

  // Stimulus-side copy of the table, used to aim queries at breakpoints.
  longint      gen_offsets[mci_pkg::MaxPoints];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int cycle_count = 0;

  always #1 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = mci_pkg::OP_LOAD;
    in_ch.point_index = '0;
    in_ch.point_time = '0;
    in_ch.point_offset = '0;
    in_ch.query_offset = '0;
    out_ch.ready = 1'b0;
  end

  // Straight line through two points at o, truncating and saturating.
  function automatic longint line_value(longint t1, longint t2, longint o1, longint o2,
                                        longint o, inout logic [1:0] st);
    longint       dt, dx, dd, r;
    logic [127:0] prod, q;
    logic [63:0]  adt, adx, add;
    logic         neg;
    dt = t2 - t1;
    dx = o - o1;
    dd = o2 - o1;
    if (dd == 0) begin
      st = mci_pkg::ST_ZERO;
      return t1;
    end
    adt = (dt < 0) ? -dt : dt;
    adx = (dx < 0) ? -dx : dx;
    add = (dd < 0) ? -dd : dd;
    prod = adt * adx;
    q = prod / add;
    if (q > (128'd1 << 33)) q = 128'd1 << 33;
    neg = ((dt < 0) != (dx < 0)) != (dd < 0);
    r = neg ? t1 - longint'(q[63:0]) : t1 + longint'(q[63:0]);
    if (r > 64'sd2147483647) begin
      r = 64'sd2147483647;
      st = mci_pkg::ST_SAT;
    end else if (r < -64'sd2147483648) begin
      r = -64'sd2147483648;
      st = mci_pkg::ST_SAT;
    end
    return r;
  endfunction

  // Time at a query offset from the predicted table.
  function automatic mute_result_t mute_at(longint o);
    mute_result_t res;
    int           n, seg;
    logic         hit;
    logic [1:0]   st;
    longint       t;
    st = mci_pkg::ST_OK;
    n = model_count;
    if (n == 0) n = 1;
    if (n > mci_pkg::MaxPoints) n = mci_pkg::MaxPoints;
    if (n < 2) begin
      t = model_times[0];
    end else if (o < model_offsets[0]) begin
      t = line_value(model_times[0], model_times[1], model_offsets[0], model_offsets[1],
                     o, st);
    end else if (o >= model_offsets[n-1]) begin
      t = line_value(model_times[n-2], model_times[n-1], model_offsets[n-2],
                     model_offsets[n-1], o, st);
    end else begin
      hit = 1'b0;
      seg = 0;
      for (int i = 0; i + 1 < n; i++) begin
        if (model_offsets[i] <= o && o < model_offsets[i+1]) begin
          seg = i;
          hit = 1'b1;
        end
      end
      if (hit) begin
        t = line_value(model_times[seg], model_times[seg+1], model_offsets[seg],
                       model_offsets[seg+1], o, st);
      end else begin
        t = model_times[0];
        st = mci_pkg::ST_MISS;
      end
    end
    res.mute_time = t[31:0];
    res.status = st;
    return res;
  endfunction

  // Driver: updates the predictor on each accepted request, then offers the next.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      in_ch.valid <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.operation == mci_pkg::OP_LOAD) begin
          model_times[in_ch.point_index] = longint'(in_ch.point_time);
          model_offsets[in_ch.point_index] = longint'(in_ch.point_offset);
        end else begin
          expected_mutes.push_back(mute_at(longint'(in_ch.query_offset)));
        end
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.operation <= pending_requests[0].operation;
          in_ch.point_index <= pending_requests[0].point_index;
          in_ch.point_time <= pending_requests[0].point_time;
          in_ch.point_offset <= pending_requests[0].point_offset;
          in_ch.query_offset <= pending_requests[0].query_offset;
          void'(pending_requests.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: compares each delivered result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_mutes.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("Unexpected result: time %h status %0d", out_ch.mute_time, out_ch.status);
      end else begin
        if (out_ch.mute_time !== expected_mutes[0].mute_time ||
            out_ch.status !== expected_mutes[0].status) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("Mismatch: expected time %h status %0d, got time %h status %0d",
                     expected_mutes[0].mute_time, expected_mutes[0].status,
                     out_ch.mute_time, out_ch.status);
        end
        void'(expected_mutes.pop_front());
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_point_count(logic [4:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'd0;
    pwdata <= {27'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    model_count = value;
  endtask

  task automatic push_load(int idx, longint t, longint o);
    mci_request_t r;
    r.operation = mci_pkg::OP_LOAD;
    r.point_index = idx[3:0];
    r.point_time = t[31:0];
    r.point_offset = o[31:0];
    r.query_offset = $urandom;
    gen_offsets[idx] = longint'(signed'(r.point_offset));
    pending_requests.push_back(r);
  endtask

  task automatic push_query(longint o);
    mci_request_t r;
    r.operation = mci_pkg::OP_QUERY;
    r.point_index = 4'($urandom);
    r.point_time = $urandom;
    r.point_offset = $urandom;
    r.query_offset = o[31:0];
    pending_requests.push_back(r);
  endtask

  // Waits until the block has nothing in flight, loads included.
  task automatic wait_idle();
    while (pending_requests.size() > 0 || expected_mutes.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Fills the table: ordered with some zero-width steps, unordered, or steep.
  task automatic build_table(int kind);
    longint o, t;
    o = -64'sd2147483648 + longint'($urandom_range(32'h7fffffff));
    for (int i = 0; i < mci_pkg::MaxPoints; i++) begin
      case (kind)
        0: begin
          t = longint'(signed'(32'($urandom)));
          push_load(i, t, o);
          o = o + (($urandom_range(9) == 0) ? 0 : longint'($urandom_range(1 << 26)));
        end
        1: begin
          push_load(i, longint'(signed'(32'($urandom))), longint'(signed'(32'($urandom))));
        end
        default: begin
          t = (i % 2) ? 64'sd2147483647 : -64'sd2147483648;
          push_load(i, t, o);
          o = o + longint'($urandom_range(1, 1 << 12));
        end
      endcase
    end
  endtask

  // Query aimed at a breakpoint, past the ends, or anywhere.
  function automatic longint pick_query(int n);
    longint o;
    int     k;
    k = $urandom_range(9);
    if (k < 5) begin
      o = gen_offsets[$urandom_range(n - 1)] + longint'($urandom_range(2000)) - 1000;
    end else if (k == 5) begin
      o = (($urandom_range(1)) != 0) ? 64'sd2147483647 : -64'sd2147483648;
    end else begin
      o = longint'(signed'(32'($urandom)));
    end
    if (o > 64'sd2147483647) o = 64'sd2147483647;
    if (o < -64'sd2147483648) o = -64'sd2147483648;
    return o;
  endfunction

  // One random phase: a fresh table, then queries with the odd reload.
  task automatic random_phase(logic [4:0] count, int kind, int items);
    int n;
    write_point_count(count);
    n = (count == 0) ? 1 : (count > mci_pkg::MaxPoints) ? mci_pkg::MaxPoints : count;
    build_table(kind);
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(7) == 0)
        push_load($urandom_range(mci_pkg::MaxPoints - 1), longint'(signed'(32'($urandom))),
                  gen_offsets[$urandom_range(mci_pkg::MaxPoints - 1)] +
                  longint'($urandom_range(1 << 16)));
      else
        push_query(pick_query(n));
    end
    wait_idle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 11;
    recv_idle_pct = 65;

    // Directed: a single point, then an ordered table probed at its edges.
    for (int i = 0; i < mci_pkg::MaxPoints; i++)
      push_load(i, 32'sd1000 * i, 32'sd65536 * i);
    push_query(-64'sd2147483648);
    push_query(64'sd5);
    wait_idle();
    write_point_count(5'd16);
    push_query(-64'sd2147483648);
    push_query(-64'sd1);
    push_query(64'sd0);
    push_query(64'sd32768);
    push_query(64'sd65536 * 7);
    push_query(64'sd65536 * 15);
    push_query(64'sd2147483647);
    // Zero-width middle segment, then steep ends that both saturate to the minimum.
    push_load(4, 32'sd7, 32'sd65536 * 3);
    push_query(64'sd65536 * 3);
    push_load(0, -64'sd2147483648, 32'sd0);
    push_load(1, 64'sd2147483647, 32'sd1);
    push_query(-64'sd2147483648);
    push_load(15, -64'sd2147483648, 32'sd65536 * 14 + 1);
    push_query(64'sd2147483647);
    // Unordered offsets, so that the query matches more than one segment.
    push_load(0, 32'sd11, 32'sd0);
    push_load(1, 32'sd22, 32'sd100);
    push_load(2, 32'sd33, 32'sd50);
    push_load(3, 32'sd44, 32'sd1000);
    push_load(15, 32'sd55, 32'sd2000);
    push_query(64'sd60);
    wait_idle();
    // Count of zero acts as one, count above the table acts as full.
    write_point_count(5'd0);
    push_query(64'sd123);
    wait_idle();
    write_point_count(5'd31);
    push_query(64'sd60);
    push_query(64'sd5000);
    wait_idle();

    // Random phases under the three idling patterns.
    random_phase(5'd16, 0, 45);
    random_phase(5'd2, 2, 35);
    send_idle_pct = 65;
    recv_idle_pct = 11;
    random_phase(5'($urandom_range(3, 15)), 0, 55);
    random_phase(5'd31, 1, 45);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(5'd1, 0, 20);
    random_phase(5'd16, 2, 45);
    random_phase(5'($urandom_range(2, 16)), 0, 55);

    if (mismatches == 0 && expected_mutes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
